// ===== hw/rtl/dlcd_pkg.sv =====
// Package for the display-list command decoder: opcodes, status codes, shared types.
// Used by dlcd_mac and the decoder top level; no dependencies.
package dlcd_pkg;

	localparam logic [7:0] OP_VADDR    = 8'h01;
	localparam logic [7:0] OP_IADDR    = 8'h02;
	localparam logic [7:0] OP_PRIM     = 8'h04;
	localparam logic [7:0] OP_JUMP     = 8'h08;
	localparam logic [7:0] OP_CALL     = 8'h0A;
	localparam logic [7:0] OP_RET      = 8'h0B;
	localparam logic [7:0] OP_END      = 8'h0C;
	localparam logic [7:0] OP_FINISH   = 8'h0F;
	localparam logic [7:0] OP_BASE     = 8'h10;
	localparam logic [7:0] OP_VTYPE    = 8'h12;
	localparam logic [7:0] OP_OFFSET   = 8'h13;
	localparam logic [7:0] OP_ORIGIN   = 8'h14;
	localparam logic [7:0] OP_BONE_NUM = 8'h2A;
	localparam logic [7:0] OP_BONE_DAT = 8'h2B;
	localparam logic [7:0] OP_TEX_LO   = 8'hB8;
	localparam logic [7:0] OP_TEX_HI   = 8'hBF;
	localparam logic [7:0] OP_TMODE    = 8'hC3;

	localparam logic [2:0] ST_RUN       = 3'd0;
	localparam logic [2:0] ST_END       = 3'd1;
	localparam logic [2:0] ST_FINISH    = 3'd2;
	localparam logic [2:0] ST_COMPLETE  = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;
	localparam logic [2:0] ST_UNDERFLOW = 3'd5;
	localparam logic [2:0] ST_STALLED   = 3'd6;

	localparam logic [0:0] CFG_LIST_START = 1'd0;
	localparam logic [0:0] CFG_STALL_ADDR = 1'd1;

	localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFC;

	// operand select for the shared multiply-add unit
	typedef struct packed {
		logic [31:0] addend;
		logic [15:0] mul_a;
		logic [15:0] mul_b;
		logic [31:0] mask;
	} mac_op_t;

	function automatic logic [2:0] elem_size(input logic [1:0] code);
		case (code)
			2'd0: elem_size = 3'd0;
			2'd1: elem_size = 3'd1;
			2'd2: elem_size = 3'd2;
			default: elem_size = 3'd4;
		endcase
	endfunction

	function automatic logic [2:0] color_size(input logic [2:0] code);
		case (code)
			3'd0: color_size = 3'd0;
			3'd1, 3'd2, 3'd3: color_size = 3'd1;
			3'd4, 3'd5, 3'd6: color_size = 3'd2;
			default: color_size = 3'd4;
		endcase
	endfunction

endpackage

// ===== hw/rtl/dlcd_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module dlcd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hw/rtl/dlcd_mac.sv =====
// Shared multiply-add unit: result = (addend + a*b + mask) & ~mask, registered.
// Depends on dlcd_pkg.
module dlcd_mac (
	input  logic             clk,
	input  dlcd_pkg::mac_op_t op,
	output logic [31:0]      result
);
	logic [31:0] prod;
	logic [31:0] sum;

	assign prod = 32'(op.mul_a) * 32'(op.mul_b);
	assign sum  = op.addend + prod + op.mask;

	always_ff @(posedge clk) begin
		result <= sum & ~op.mask;
	end
endmodule

// ===== hw/rtl/display_list_command_decoder_core.sv =====
// Display-list command decoder: top level with sequencer and state registers.
// Depends on dlcd_pkg, dlcd_mac, dlcd_ram.
// Sequence: an accepted command goes from S_EXEC to S_DONE and S_OUT; when the list
// is ended, complete or stalled, S_EXEC goes straight to S_OUT. Primitives and vertex
// type pass through S_MAC first (vertex type: eight passes through the shared
// multiply-add unit plus capture); return passes through S_RET (stack RAM read). A new
// command is accepted only in S_IDLE, after the result is taken; the sink can hold it off.
// Reset: arst_n clears all control and architectural registers; stack RAMs are
// not cleared (entries are always pushed before popped).
module display_list_command_decoder_core #(
	parameter int STACK_DEPTH   = 64,
	parameter int BONE_MATRICES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // op[7:0], argument[31:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	// next_address[31:0], vertex_address[63:32], index_address[95:64],
	// vertex_stride[105:96], status[108:106], bone_slot[115:109],
	// bone_word[147:116], tex_level[151:148], tex_width_log2[155:152],
	// tex_height_log2[159:156], texture_format[163:160]
	output logic [167:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int RAM_DEPTH = (STACK_DEPTH > 1) ? STACK_DEPTH : 2;
	localparam int SDW = $clog2(STACK_DEPTH + 1);
	localparam logic [6:0] NO_BONE = 7'(BONE_MATRICES * 12);
	localparam logic [23:0] BONE_LIMIT = 24'(BONE_MATRICES * 12);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_MAC  = 6'b000100,
		S_RET  = 6'b001000,
		S_DONE = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	logic [7:0]  op_q;
	logic [23:0] arg_q;
	logic [31:0] stall_q, lp_q, boff_q, vp_q, ip_q;
	logic [7:0]  bhigh_q;
	logic [23:0] vfmt_q, bidx_q;
	logic [9:0]  stride_q;
	logic [SDW-1:0] sdepth_q;
	logic end_q, fin_q;
	logic [3:0] tmode_q;
	logic [2:0] status_q;
	logic [6:0] bslot_q;
	logic [31:0] bword_q;
	logic [3:0] tlev_q, tw_q, th_q;
	logic [3:0] step_q;
	logic prim_idx_q;

	dlcd_pkg::mac_op_t mop;
	logic [31:0] mres;
	logic [31:0] target;
	logic [31:0] ret_rd, off_rd;
	logic push;
	logic [SAW-1:0] waddr, raddr;

	dlcd_mac u_mac (.clk(clk), .op(mop), .result(mres));

	assign push  = (state_q == S_EXEC) && op_q == dlcd_pkg::OP_CALL
		&& !end_q && (lp_q < stall_q)
		&& !(sdepth_q >= SDW'(STACK_DEPTH));
	assign waddr = SAW'(sdepth_q);
	assign raddr = SAW'(sdepth_q - SDW'(1));

	dlcd_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ret (
		.clk(clk), .we(push), .waddr(waddr), .wdata(lp_q + 32'd4),
		.raddr(raddr), .rdata(ret_rd));
	dlcd_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_off (
		.clk(clk), .we(push), .waddr(waddr), .wdata(boff_q),
		.raddr(raddr), .rdata(off_rd));

	assign target = ({bhigh_q, arg_q}) + boff_q;

	// stride sequence fields
	logic [1:0] f_t, f_n, f_p, f_w;
	logic [2:0] f_c;
	logic [3:0] f_wc, f_mc;
	logic [2:0] al;
	assign f_t  = vfmt_q[1:0];
	assign f_c  = vfmt_q[4:2];
	assign f_n  = vfmt_q[6:5];
	assign f_p  = vfmt_q[8:7];
	assign f_w  = vfmt_q[10:9];
	assign f_wc = {1'b0, vfmt_q[16:14]} + 4'd1;
	assign f_mc = {1'b0, vfmt_q[20:18]} + 4'd1;

	always_comb begin
		logic [2:0] a0, a1;
		a0 = dlcd_pkg::elem_size(f_w) > dlcd_pkg::color_size(f_c)
			? dlcd_pkg::elem_size(f_w) : dlcd_pkg::color_size(f_c);
		a1 = dlcd_pkg::elem_size(f_n) > dlcd_pkg::elem_size(f_t)
			? dlcd_pkg::elem_size(f_n) : dlcd_pkg::elem_size(f_t);
		a0 = a0 > a1 ? a0 : a1;
		al = a0 > dlcd_pkg::elem_size(f_p) ? a0 : dlcd_pkg::elem_size(f_p);
	end

	function automatic logic [31:0] pad_of(input logic [2:0] sz);
		pad_of = (sz == 3'd0) ? 32'd0 : 32'(sz - 3'd1);
	endfunction

	// each vertex-type pass after the first takes the previous pass's registered result from mres
	always_comb begin
		mop = '{addend: 32'd0, mul_a: 16'd0, mul_b: 16'd0, mask: 32'd0};
		if (state_q == S_MAC && op_q == dlcd_pkg::OP_PRIM) begin
			mop.mul_a = arg_q[15:0];
			if (prim_idx_q) begin
				mop.addend = ip_q;
				mop.mul_b  = 16'(dlcd_pkg::elem_size(vfmt_q[12:11]));
			end else begin
				mop.addend = vp_q;
				mop.mul_b  = 16'(stride_q);
			end
		end else if (state_q == S_MAC) begin
			case (step_q)
				4'd0: begin
					mop.mul_a = 16'(dlcd_pkg::elem_size(f_w));
					mop.mul_b = 16'(f_wc);
				end
				4'd1: begin
					mop.addend = mres;
					mop.mask   = pad_of(dlcd_pkg::elem_size(f_t));
				end
				4'd2: begin
					mop.addend = mres;
					mop.mul_a  = 16'(dlcd_pkg::elem_size(f_t));
					mop.mul_b  = 16'd2;
					mop.mask   = pad_of(dlcd_pkg::color_size(f_c));
				end
				4'd3: begin
					mop.addend = mres + 32'(dlcd_pkg::color_size(f_c));
					mop.mask   = pad_of(dlcd_pkg::elem_size(f_n));
				end
				4'd4: begin
					mop.addend = mres;
					mop.mul_a  = 16'(dlcd_pkg::elem_size(f_n));
					mop.mul_b  = 16'd3;
					mop.mask   = pad_of(dlcd_pkg::elem_size(f_p));
				end
				4'd5: begin
					mop.addend = mres;
					mop.mul_a  = 16'(dlcd_pkg::elem_size(f_p));
					mop.mul_b  = 16'd3;
				end
				4'd6: begin
					mop.mul_a = mres[15:0];
					mop.mul_b = 16'(f_mc);
				end
				default: begin
					mop.addend = mres;
					mop.mask   = pad_of(al);
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = {4'd0, tmode_q, th_q, tw_q, tlev_q, bword_q, bslot_q,
		status_q, stride_q, ip_q, vp_q, lp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= '0; lp_q <= '0; boff_q <= '0; vp_q <= '0; ip_q <= '0;
			bhigh_q <= '0; vfmt_q <= '0; bidx_q <= '0; stride_q <= '0;
			sdepth_q <= '0; end_q <= 1'b0; fin_q <= 1'b0; tmode_q <= '0;
			step_q <= '0; prim_idx_q <= 1'b0;
			op_q <= '0; arg_q <= '0; status_q <= '0; bslot_q <= '0;
			bword_q <= '0; tlev_q <= '0; tw_q <= '0; th_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == dlcd_pkg::CFG_LIST_START) begin
					lp_q <= cfg_data; end_q <= 1'b0; fin_q <= 1'b0;
				end else begin
					stall_q <= cfg_data;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q <= s_tdata[7:0];
						arg_q <= s_tdata[31:8];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= dlcd_pkg::ST_RUN;
					bslot_q <= NO_BONE; bword_q <= '0;
					tlev_q <= 4'd8; tw_q <= '0; th_q <= '0;
					state_q <= S_DONE;
					if (end_q && fin_q) begin
						status_q <= dlcd_pkg::ST_COMPLETE; state_q <= S_OUT;
					end else if (end_q) begin
						status_q <= dlcd_pkg::ST_END; state_q <= S_OUT;
					end else if (lp_q >= stall_q) begin
						status_q <= dlcd_pkg::ST_STALLED; state_q <= S_OUT;
					end else begin
						lp_q <= lp_q + 32'd4;
						case (op_q)
							dlcd_pkg::OP_VADDR: vp_q <= target;
							dlcd_pkg::OP_IADDR: ip_q <= target;
							dlcd_pkg::OP_PRIM: begin
								prim_idx_q <= ip_q != 32'd0 && vfmt_q[12:11] != 2'd0;
								state_q <= S_MAC;
							end
							dlcd_pkg::OP_JUMP: lp_q <= target & dlcd_pkg::WORD_MASK;
							dlcd_pkg::OP_CALL: begin
								if (sdepth_q >= SDW'(STACK_DEPTH)) begin
									status_q <= dlcd_pkg::ST_OVERFLOW;
								end else begin
									sdepth_q <= sdepth_q + SDW'(1);
									lp_q <= target & dlcd_pkg::WORD_MASK;
								end
							end
							dlcd_pkg::OP_RET: begin
								if (sdepth_q == '0) begin
									status_q <= dlcd_pkg::ST_UNDERFLOW;
								end else begin
									state_q <= S_RET;
								end
							end
							dlcd_pkg::OP_END: end_q <= 1'b1;
							dlcd_pkg::OP_FINISH: fin_q <= 1'b1;
							dlcd_pkg::OP_BASE: bhigh_q <= arg_q[23:16];
							dlcd_pkg::OP_VTYPE: begin
								vfmt_q <= arg_q; step_q <= '0; state_q <= S_MAC;
							end
							dlcd_pkg::OP_OFFSET: boff_q <= {arg_q, 8'd0};
							dlcd_pkg::OP_ORIGIN: boff_q <= lp_q;
							dlcd_pkg::OP_BONE_NUM: bidx_q <= arg_q;
							dlcd_pkg::OP_BONE_DAT: begin
								if (bidx_q < BONE_LIMIT) begin
									bslot_q <= bidx_q[6:0];
									bword_q <= {arg_q, 8'd0};
									bidx_q <= bidx_q + 24'd1;
								end
							end
							dlcd_pkg::OP_TMODE: tmode_q <= arg_q[3:0];
							default: begin
								if (op_q inside {[dlcd_pkg::OP_TEX_LO:dlcd_pkg::OP_TEX_HI]}) begin
									tlev_q <= {1'b0, op_q[2:0]};
									th_q <= arg_q[11:8] > 4'd9 ? 4'd9 : arg_q[11:8];
									tw_q <= arg_q[3:0] > 4'd9 ? 4'd9 : arg_q[3:0];
								end
							end
						endcase
					end
				end
				S_MAC: begin
					// one pass per cycle; result lands next cycle
					step_q <= step_q + 4'd1;
					if (op_q == dlcd_pkg::OP_PRIM) begin
						if (step_q == 4'd1) begin
							if (prim_idx_q) ip_q <= mres; else vp_q <= mres;
							step_q <= '0;
							state_q <= S_DONE;
						end
					end else if (step_q == 4'd8) begin
						stride_q <= mres[9:0];
						step_q <= '0;
						state_q <= S_DONE;
					end
				end
				S_RET: begin
					// read data of the stack RAM is valid here
					sdepth_q <= sdepth_q - SDW'(1);
					lp_q <= ret_rd;
					boff_q <= off_rd;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (status_q == dlcd_pkg::ST_RUN) begin
						if (end_q && fin_q) status_q <= dlcd_pkg::ST_COMPLETE;
						else if (end_q) status_q <= dlcd_pkg::ST_END;
						else if (fin_q) status_q <= dlcd_pkg::ST_FINISH;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	ap_depth: assert property (@(posedge clk) disable iff (!arst_n)
		sdepth_q <= SDW'(STACK_DEPTH)) else $error("stack depth beyond limit");
	ap_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> sdepth_q == $past(sdepth_q) + SDW'(1)) else $error("push without depth step");
	ap_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input and output open together");
	ap_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
`endif
endmodule

// ===== tb/display_list_command_decoder_core_test.sv =====
// Testbench for the display-list command decoder: drives command words on the
// stream input, predicts each result in a local decoder model and compares.
// Depends on dlcd_pkg and display_list_command_decoder_core.
module display_list_command_decoder_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_LIMIT = 64;
	localparam int BONE_LIMIT = 8;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [3:0]  texture_format;
		logic [3:0]  tex_height_log2;
		logic [3:0]  tex_width_log2;
		logic [3:0]  tex_level;
		logic [31:0] bone_word;
		logic [6:0]  bone_slot;
		logic [2:0]  status;
		logic [9:0]  vertex_stride;
		logic [31:0] index_address;
		logic [31:0] vertex_address;
		logic [31:0] next_address;
	} decode_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [167:0] m_tdata;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [31:0] cfg_data = '0;

	display_list_command_decoder_core DUT (.*);

	always #5 clk = ~clk;

	// decoder state mirror
	logic [31:0] list_start_q, stall_q, lp, base_off, vptr, iptr;
	logic [7:0]  base_hi;
	logic [23:0] vfmt, bone_idx;
	logic [9:0]  stride_q;
	logic [31:0] ret_stk [STACK_LIMIT];
	logic [31:0] off_stk [STACK_LIMIT];
	int unsigned depth;
	logic ended, finished;
	logic [3:0] tmode;

	decode_result_t expected_results[$];
	int errors = 0;
	int src_idle = 28, snk_idle = 80;
	int quiet_cycles = 0;

	function automatic int unsigned esz(input int unsigned c);
		return (c == 0) ? 0 : (c == 1) ? 1 : (c == 2) ? 2 : 4;
	endfunction
	function automatic int unsigned csz(input int unsigned c);
		return (c == 0) ? 0 : (c <= 3) ? 1 : (c <= 6) ? 2 : 4;
	endfunction
	function automatic int unsigned aup(input int unsigned v, input int unsigned m);
		return (v + m) & ~m;
	endfunction

	function automatic logic [9:0] vertex_stride_of(input logic [23:0] f);
		int unsigned t, c, n, p, w, wc, mc, s, al;
		t = f[1:0]; c = f[4:2]; n = f[6:5]; p = f[8:7]; w = f[10:9];
		wc = f[16:14] + 1; mc = f[20:18] + 1;
		s = esz(w) * wc;
		s = aup(s, esz(t) == 4 ? 3 : esz(t) == 2 ? 1 : 0);
		s += esz(t) * 2;
		s = aup(s, csz(c) == 4 ? 3 : csz(c) == 2 ? 1 : 0);
		s += csz(c);
		s = aup(s, esz(n) == 4 ? 3 : esz(n) == 2 ? 1 : 0);
		s += esz(n) * 3;
		s = aup(s, esz(p) == 4 ? 3 : esz(p) == 2 ? 1 : 0);
		s += esz(p) * 3;
		s *= mc;
		al = esz(w);
		if (csz(c) > al) al = csz(c);
		if (esz(n) > al) al = esz(n);
		if (esz(t) > al) al = esz(t);
		if (esz(p) > al) al = esz(p);
		if (al != 0) s = aup(s, al - 1);
		return s[9:0];
	endfunction

	function automatic decode_result_t decode_command(input logic [7:0] op,
			input logic [23:0] arg);
		decode_result_t r;
		logic [31:0] tgt;
		int unsigned ib;
		r = '0;
		r.status = dlcd_pkg::ST_RUN;
		r.bone_slot = 7'(BONE_LIMIT * 12);
		r.tex_level = 4'd8;
		tgt = {base_hi, arg} + base_off;
		if (ended && finished) r.status = dlcd_pkg::ST_COMPLETE;
		else if (ended) r.status = dlcd_pkg::ST_END;
		else if (lp >= stall_q) r.status = dlcd_pkg::ST_STALLED;
		else begin
			lp = lp + 4;
			case (op)
				dlcd_pkg::OP_VADDR: vptr = tgt;
				dlcd_pkg::OP_IADDR: iptr = tgt;
				dlcd_pkg::OP_PRIM: begin
					ib = esz(vfmt[12:11]);
					if (iptr != 0 && ib != 0) iptr = iptr + ib * arg[15:0];
					else vptr = vptr + arg[15:0] * stride_q;
				end
				dlcd_pkg::OP_JUMP: lp = tgt & dlcd_pkg::WORD_MASK;
				dlcd_pkg::OP_CALL: begin
					if (depth >= STACK_LIMIT) r.status = dlcd_pkg::ST_OVERFLOW;
					else begin
						ret_stk[depth] = lp;
						off_stk[depth] = base_off;
						depth++;
						lp = tgt & dlcd_pkg::WORD_MASK;
					end
				end
				dlcd_pkg::OP_RET: begin
					if (depth == 0) r.status = dlcd_pkg::ST_UNDERFLOW;
					else begin
						depth--;
						lp = ret_stk[depth];
						base_off = off_stk[depth];
					end
				end
				dlcd_pkg::OP_END: ended = 1;
				dlcd_pkg::OP_FINISH: finished = 1;
				dlcd_pkg::OP_BASE: base_hi = arg[23:16];
				dlcd_pkg::OP_VTYPE: begin
					vfmt = arg;
					stride_q = vertex_stride_of(arg);
				end
				dlcd_pkg::OP_OFFSET: base_off = {arg, 8'h00};
				dlcd_pkg::OP_ORIGIN: base_off = lp - 4;
				dlcd_pkg::OP_BONE_NUM: bone_idx = arg;
				dlcd_pkg::OP_BONE_DAT: begin
					if (bone_idx / 12 < BONE_LIMIT) begin
						r.bone_slot = bone_idx[6:0];
						r.bone_word = {arg, 8'h00};
						bone_idx = bone_idx + 1;
					end
				end
				dlcd_pkg::OP_TMODE: tmode = arg[3:0];
				default: begin
					if (op >= dlcd_pkg::OP_TEX_LO && op <= dlcd_pkg::OP_TEX_HI) begin
						r.tex_level = 4'(op - dlcd_pkg::OP_TEX_LO);
						r.tex_height_log2 = arg[11:8] > 9 ? 4'd9 : arg[11:8];
						r.tex_width_log2 = arg[3:0] > 9 ? 4'd9 : arg[3:0];
					end
				end
			endcase
			if (r.status == dlcd_pkg::ST_RUN) begin
				if (ended && finished) r.status = dlcd_pkg::ST_COMPLETE;
				else if (ended) r.status = dlcd_pkg::ST_END;
				else if (finished) r.status = dlcd_pkg::ST_FINISH;
			end
		end
		r.next_address = lp;
		r.vertex_address = vptr;
		r.index_address = iptr;
		r.vertex_stride = stride_q;
		r.texture_format = tmode;
		return r;
	endfunction

	// drive at the falling edge; tready is stable there, so the next rising edge accepts
	task automatic send_command(input logic [7:0] op, input logic [23:0] arg);
		while ($urandom_range(99) < src_idle) @(negedge clk);
		s_tdata = {arg, op};
		s_tvalid = 1;
		expected_results.push_back(decode_command(op, arg));
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic drain();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [31:0] value);
		drain();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == dlcd_pkg::CFG_LIST_START) begin
			list_start_q = value;
			lp = value;
			ended = 0;
			finished = 0;
		end else stall_q = value;
	endtask

	// compare each output transfer with the oldest prediction
	always @(posedge clk) begin
		decode_result_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[163:0];
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					$display("%0t mismatch expected %h actual %h", $time, want, got);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) m_tready <= ($urandom_range(99) >= snk_idle);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[display_list_command_decoder_core] ERROR");
			$finish;
		end
	end

	task automatic test_directed();
		write_register(dlcd_pkg::CFG_STALL_ADDR, 32'hFFFF_FFFF);
		write_register(dlcd_pkg::CFG_LIST_START, 32'h0000_1000);
		send_command(dlcd_pkg::OP_RET, 24'h0);
		send_command(dlcd_pkg::OP_BASE, 24'hFF0000);
		send_command(dlcd_pkg::OP_VADDR, 24'hFFFFFF);
		send_command(dlcd_pkg::OP_BASE, 24'h000000);
		send_command(dlcd_pkg::OP_OFFSET, 24'hFFFFFF);
		send_command(dlcd_pkg::OP_IADDR, 24'h000123);
		send_command(dlcd_pkg::OP_VTYPE, 24'hFFFFFF);
		send_command(dlcd_pkg::OP_PRIM, 24'hFFFFFF);
		send_command(dlcd_pkg::OP_VTYPE, 24'h0001FF);
		send_command(dlcd_pkg::OP_PRIM, 24'h000010);
		send_command(dlcd_pkg::OP_ORIGIN, 24'h0);
		send_command(dlcd_pkg::OP_CALL, 24'h000040);
		send_command(dlcd_pkg::OP_RET, 24'h0);
		send_command(dlcd_pkg::OP_JUMP, 24'h000203);
		send_command(dlcd_pkg::OP_BONE_NUM, 24'd95);
		send_command(dlcd_pkg::OP_BONE_DAT, 24'hFFFFFF);
		send_command(dlcd_pkg::OP_BONE_DAT, 24'h000001);
		send_command(dlcd_pkg::OP_TEX_LO, 24'h000F0F);
		send_command(dlcd_pkg::OP_TEX_HI, 24'h000302);
		send_command(dlcd_pkg::OP_TMODE, 24'hFFFFFF);
		send_command(8'hFF, 24'hABCDEF);
		send_command(dlcd_pkg::OP_FINISH, 24'h0);
		send_command(dlcd_pkg::OP_END, 24'h0);
		send_command(dlcd_pkg::OP_PRIM, 24'h1);
	endtask

	task automatic test_stack_limits();
		write_register(dlcd_pkg::CFG_LIST_START, 32'h0);
		write_register(dlcd_pkg::CFG_STALL_ADDR, 32'hFFFF_FFFF);
		repeat (STACK_LIMIT + 1) send_command(dlcd_pkg::OP_CALL, 24'($urandom));
		repeat (STACK_LIMIT + 1) send_command(dlcd_pkg::OP_RET, 24'($urandom));
		send_command(dlcd_pkg::OP_END, 24'h0);
		send_command(dlcd_pkg::OP_VADDR, 24'h5);
	endtask

	task automatic test_stall();
		write_register(dlcd_pkg::CFG_LIST_START, 32'hFFFF_FFF0);
		write_register(dlcd_pkg::CFG_STALL_ADDR, 32'hFFFF_FFF8);
		repeat (4) send_command(dlcd_pkg::OP_TMODE, 24'($urandom));
		write_register(dlcd_pkg::CFG_STALL_ADDR, 32'h0);
		send_command(dlcd_pkg::OP_VADDR, 24'h1);
	endtask

	function automatic logic [7:0] pick_op();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 4) return 8'($urandom);
		if (k < 6) return dlcd_pkg::OP_END;
		if (k < 8) return dlcd_pkg::OP_FINISH;
		if (k < 18) return dlcd_pkg::OP_VTYPE;
		if (k < 30) return dlcd_pkg::OP_PRIM;
		if (k < 36) return dlcd_pkg::OP_CALL;
		if (k < 44) return dlcd_pkg::OP_RET;
		if (k < 48) return dlcd_pkg::OP_JUMP;
		if (k < 54) return dlcd_pkg::OP_VADDR;
		if (k < 60) return dlcd_pkg::OP_IADDR;
		if (k < 63) return dlcd_pkg::OP_BASE;
		if (k < 66) return dlcd_pkg::OP_OFFSET;
		if (k < 68) return dlcd_pkg::OP_ORIGIN;
		if (k < 71) return dlcd_pkg::OP_BONE_NUM;
		if (k < 82) return dlcd_pkg::OP_BONE_DAT;
		if (k < 85) return dlcd_pkg::OP_TMODE;
		return 8'(dlcd_pkg::OP_TEX_LO + $urandom_range(7));
	endfunction

	task automatic test_random(input int count);
		logic [7:0] op;
		logic [23:0] arg;
		int sent;
		sent = 0;
		while (sent < count) begin
			if (ended || lp >= stall_q || $urandom_range(199) == 0) begin
				write_register(dlcd_pkg::CFG_LIST_START,
					$urandom_range(3) == 0 ? $urandom : 32'($urandom_range(4096)));
				write_register(dlcd_pkg::CFG_STALL_ADDR,
					$urandom_range(9) == 0 ? $urandom : 32'hFFFF_FFF0);
			end
			op = pick_op();
			arg = 24'($urandom);
			if (op == dlcd_pkg::OP_BONE_NUM) arg = 24'($urandom_range(100));
			if (op == dlcd_pkg::OP_IADDR && $urandom_range(3) == 0) arg = 24'h0;
			send_command(op, arg);
			sent++;
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1;
		list_start_q = 0; stall_q = 0; lp = 0; base_off = 0; vptr = 0; iptr = 0;
		base_hi = 0; vfmt = 0; bone_idx = 0; stride_q = 0; depth = 0;
		ended = 0; finished = 0; tmode = 0;
		test_directed();
		test_stack_limits();
		test_stall();
		test_random(350);
		src_idle = 80; snk_idle = 28;
		test_random(350);
		src_idle = 0; snk_idle = 0;
		test_random(350);
		drain();
		if (errors == 0 && expected_results.size() == 0)
			$display("[display_list_command_decoder_core] OK");
		else
			$display("[display_list_command_decoder_core] ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/dlcd_pkg.sv
hw/rtl/dlcd_ram.sv
hw/rtl/dlcd_mac.sv
hw/rtl/display_list_command_decoder_core.sv
tb/display_list_command_decoder_core_test.sv
